[design/d2i_pkg.sv]
package d2i_pkg;
   localparam logic [1:0] OP_SINGLE   = 2'd0;
   localparam logic [1:0] OP_DOUBLE   = 2'd1;
   localparam logic [1:0] OP_EXTENDED = 2'd2;
   localparam logic [1:0] OP_UNUSED   = 2'd3;

   typedef struct packed {
      logic [63:0] image_high;
      logic [63:0] image_low;
      logic        too_small;
      logic        too_large;
   } result_type;

   function automatic logic [63:0] swap_words(input logic [63:0] v);
      swap_words = {v[39:32], v[47:40], v[55:48], v[63:56],
                    v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction
endpackage

[design/double_to_ieee_format_convert.sv]
// Pipeline: an accepted request passes through the input reg and then the result reg, which drives rsp_valid.
// Throughput: one transaction per cycle while rsp_ready is high; conversion is one combinational pass.
// Reset: synchronous active-high reset clears valids and swap_ff.
module double_to_ieee_format_convert
   import d2i_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [63:0] req_value_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_image_high,
   output logic [63:0] rsp_image_low,
   output logic        rsp_too_small,
   output logic        rsp_too_large,
   input  logic        csr_write_enable,
   input  logic        csr_write_data
);
   logic        swap_ff;
   logic        in_valid_ff;
   logic [1:0]  op_ff;
   logic [63:0] val_ff;
   logic        out_valid_ff;
   result_type  res_ff;
   result_type  res_in;
   logic        adv;

   // advance stage 2 when result is empty or being taken
   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || adv;

   d2i_convert u_conv (
      .op(op_ff), .value_bits(val_ff), .byte_swap(swap_ff), .result(res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) swap_ff <= csr_write_data;
         if (req_ready) in_valid_ff <= req_valid;
         if (adv) out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         op_ff  <= req_op;
         val_ff <= req_value_bits;
      end
      if (adv && in_valid_ff) res_ff <= res_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_image_high = res_ff.image_high;
   assign rsp_image_low  = res_ff.image_low;
   assign rsp_too_small  = res_ff.too_small;
   assign rsp_too_large  = res_ff.too_large;

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_too_small && rsp_too_large))
      else $error("both flags set");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_image_high))
      else $error("result dropped");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && adv |=> rsp_valid)
      else $error("item lost");
endmodule

[design/d2i_convert.sv]
module d2i_convert
   import d2i_pkg::*;
(
   input  logic [1:0]  op,
   input  logic [63:0] value_bits,
   input  logic        byte_swap,
   output result_type  result
);
   logic        sign;
   logic [10:0] ef;
   logic [51:0] fr;
   logic [5:0]  lz;
   logic [51:0] f52;
   logic signed [16:0] e;
   logic signed [16:0] expo;
   logic signed [16:0] maxe;
   logic signed [16:0] bias;
   logic        underflow, overflow, active;
   logic [14:0] ex;
   logic [63:0] hi, lo;

   assign sign = value_bits[63];
   assign ef   = value_bits[62:52];
   assign fr   = value_bits[51:0];

   // leading-zero count of the subnormal fraction
   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (fr[i]) lz = 6'(51 - i);
      end
   end

   always_comb begin
      unique case (op)
         OP_SINGLE:   maxe = 17'sd255;
         OP_DOUBLE:   maxe = 17'sd2047;
         default:     maxe = 17'sd32767;
      endcase
      bias   = maxe >>> 1;
      active = (op != OP_UNUSED) && !(ef == 11'd0 && fr == 52'd0);
      if (ef == 11'd0) begin
         e   = -17'sd1023 - 17'(lz);
         f52 = 52'(fr << (lz + 6'd1));
      end else begin
         e   = 17'($signed({6'd0, ef})) - 17'sd1023;
         f52 = fr;
      end
      expo     = e + bias;
      overflow = active && ((ef == 11'h7FF) || (expo > maxe - 17'sd1));
      underflow = active && !overflow && (expo < 17'sd1);
      if (underflow) begin
         ex = 15'd0;
      end else if (overflow) begin
         ex = 15'(maxe);
      end else begin
         ex = expo[14:0];
      end
      hi = 64'd0;
      lo = 64'd0;
      if (active) begin
         unique case (op)
            OP_SINGLE:
               hi = {sign, ex[7:0], (underflow || overflow) ? 23'd0 : f52[51:29], 32'd0};
            OP_DOUBLE:
               hi = {sign, ex[10:0], (underflow || overflow) ? 52'd0 : f52};
            default: begin
               hi = {sign, ex, ~underflow, (underflow || overflow) ? 47'd0 : f52[51:5]};
               lo = {(underflow || overflow) ? 5'd0 : f52[4:0], 59'd0};
            end
         endcase
      end
      result.image_high = byte_swap ? swap_words(hi) : hi;
      result.image_low  = byte_swap ? swap_words(lo) : lo;
      result.too_small  = underflow;
      result.too_large  = overflow;
   end
endmodule
